@@ rtl/bgu_pkg.sv @@
// Shared types, constants and arithmetic helpers for the bilinear grid upsampler.
package bgu_pkg;

  localparam int COLS_DEF  = 256;
  localparam int STEP_MAX  = 8;
  localparam int STEP_W    = 4;
  localparam int COLS_W    = 9;
  localparam int DEN_W     = 7;
  localparam int REM_W     = 6;
  localparam int ACC_W     = 35;
  localparam int DIV_BITS  = 7;
  localparam int DIV_STEPS = ACC_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int SAMPLE_W  = 32;
  localparam int OUT_W     = 56;

  typedef enum logic [0:0] {
    CFG_STEP = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] q;
    logic [REM_W-1:0]        r;
  } qr_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] c00;
    logic signed [ACC_W-1:0] qx;
    logic signed [ACC_W-1:0] qy;
    logic signed [ACC_W-1:0] qe;
    logic [REM_W-1:0]        rx;
    logic [REM_W-1:0]        ry;
    logic [REM_W-1:0]        re;
    logic [DEN_W-1:0]        den;
    logic [STEP_W-1:0]       step;
    logic [7:0]              row;
    logic [7:0]              col;
  } job_t;

  function automatic logic [STEP_W-1:0] clamp_step(logic [STEP_W-1:0] s);
    logic [STEP_W-1:0] res;
    res = s;
    if (s == '0) begin
      res = STEP_W'(1);
    end else if (s > STEP_W'(STEP_MAX)) begin
      res = STEP_W'(STEP_MAX);
    end
    return res;
  endfunction

  function automatic qr_t qr_add(qr_t a, qr_t b, logic [DEN_W-1:0] den);
    logic [REM_W:0] sum;
    logic           carry;
    qr_t            res;
    sum   = {1'b0, a.r} + {1'b0, b.r};
    carry = (sum >= (REM_W+1)'(den));
    res.r = carry ? REM_W'(sum - (REM_W+1)'(den)) : sum[REM_W-1:0];
    res.q = a.q + b.q + ACC_W'(carry);
    return res;
  endfunction

endpackage

@@ rtl/bgu_div.sv @@
// Multi-cycle floor divider of a signed value by a small positive divisor.
module bgu_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [bgu_pkg::ACC_W-1:0] n,
  input  logic [bgu_pkg::DEN_W-1:0]        d,
  output logic                             busy,
  output logic signed [bgu_pkg::ACC_W-1:0] q,
  output logic [bgu_pkg::REM_W-1:0]        r
);

  logic                            busy_r;
  logic [bgu_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [bgu_pkg::ACC_W-1:0]       mag_r;
  logic [bgu_pkg::ACC_W-1:0]       mag_nxt;
  logic [bgu_pkg::DEN_W-1:0]       rem_r;
  logic [bgu_pkg::DEN_W-1:0]       rem_nxt;
  logic [bgu_pkg::DEN_W-1:0]       d_r;
  logic                            neg_r;

  always_comb begin
    mag_nxt = mag_r;
    rem_nxt = rem_r;
    for (int k = 0; k < bgu_pkg::DIV_BITS; k++) begin
      rem_nxt = {rem_nxt[bgu_pkg::DEN_W-2:0], mag_nxt[bgu_pkg::ACC_W-1]};
      mag_nxt = {mag_nxt[bgu_pkg::ACC_W-2:0], 1'b0};
      if (rem_nxt >= d_r) begin
        rem_nxt    = rem_nxt - d_r;
        mag_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + bgu_pkg::DIV_CNT_W'(1);
      if (cnt_r == bgu_pkg::DIV_CNT_W'(bgu_pkg::DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= n[bgu_pkg::ACC_W-1] ? bgu_pkg::ACC_W'(-n) : bgu_pkg::ACC_W'(n);
      neg_r <= n[bgu_pkg::ACC_W-1];
      rem_r <= '0;
      d_r   <= d;
    end else if (busy_r) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_comb begin
    if (!neg_r) begin
      q = signed'(mag_r);
      r = rem_r[bgu_pkg::REM_W-1:0];
    end else if (rem_r != '0) begin
      q = signed'(~mag_r);
      r = bgu_pkg::REM_W'(d_r - rem_r);
    end else begin
      q = signed'(-mag_r);
      r = '0;
    end
  end

  assign busy = busy_r;

endmodule

@@ rtl/bgu_front.sv @@
// Front end: sample intake, line buffer, corner tracking and per-cell setup divisions.
module bgu_front #(
  parameter int MAX_COARSE_COLS = bgu_pkg::COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bgu_pkg::SAMPLE_W-1:0]      in_tdata,
  input  logic                              in_tuser,
  input  logic [bgu_pkg::STEP_W-1:0]        step_cfg,
  input  logic [bgu_pkg::COLS_W-1:0]        cols_cfg,
  output logic                              job_valid,
  input  logic                              job_ready,
  output bgu_pkg::job_t                     job
);

  localparam int AW    = $clog2(MAX_COARSE_COLS);
  localparam int CMP_W = (AW + 1 > bgu_pkg::COLS_W) ? AW + 1 : bgu_pkg::COLS_W;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_READ = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic                               accept;
  logic [AW-1:0]                      col;
  logic [AW-1:0]                      col_m1;
  logic [7:0]                         row;
  logic [CMP_W-1:0]                   cols_eff;
  logic [CMP_W-1:0]                   col_inc;
  logic                               wrap;
  logic [AW-1:0]                      col_cnt_r, col_cnt_nxt;
  logic [7:0]                         row_cnt_r, row_cnt_nxt;

  logic [bgu_pkg::SAMPLE_W-1:0]       row_mem [MAX_COARSE_COLS];
  logic signed [bgu_pkg::SAMPLE_W-1:0] above_r;
  logic signed [bgu_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [bgu_pkg::SAMPLE_W-1:0] ul_r;
  logic signed [bgu_pkg::SAMPLE_W-1:0] ll_r;
  logic signed [bgu_pkg::SAMPLE_W-1:0] c00_r;
  logic                               cell_r;
  logic [7:0]                         cell_row_r;
  logic [7:0]                         cell_col_r;
  logic [bgu_pkg::STEP_W-1:0]         step_r;

  logic signed [bgu_pkg::ACC_W-1:0]   e00, e10, e01, e11;
  logic signed [bgu_pkg::ACC_W-1:0]   nx, ny, ne;
  logic signed [bgu_pkg::ACC_W-1:0]   qx, qy, qe;
  logic [bgu_pkg::REM_W-1:0]          rx, ry, re;
  logic [bgu_pkg::DEN_W-1:0]          step7;
  logic [bgu_pkg::DEN_W-1:0]          den;
  logic [bgu_pkg::REM_W-1:0]          step6;
  logic                               div_start;
  logic                               busy_x, busy_y, busy_e;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == F_IDLE);

  assign col    = in_tuser ? '0 : col_cnt_r;
  assign row    = in_tuser ? '0 : row_cnt_r;
  assign col_m1 = col - AW'(1);

  always_comb begin
    cols_eff = CMP_W'(cols_cfg);
    if (cols_eff < CMP_W'(2)) begin
      cols_eff = CMP_W'(2);
    end else if (cols_eff > CMP_W'(MAX_COARSE_COLS)) begin
      cols_eff = CMP_W'(MAX_COARSE_COLS);
    end
  end

  assign col_inc = CMP_W'(col) + CMP_W'(1);
  assign wrap    = (col_inc >= cols_eff);

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (accept) begin
      if (wrap) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (row == 8'hFF) ? row : row + 8'd1;
      end else begin
        col_cnt_nxt = col_inc[AW-1:0];
        row_cnt_nxt = row;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (accept) state_nxt = F_READ;
      F_READ: state_nxt = cell_r ? F_DIV : F_IDLE;
      F_DIV:  if (!(busy_x || busy_y || busy_e)) state_nxt = F_PUSH;
      F_PUSH: if (job_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_mem[col] <= in_tdata;
      above_r      <= signed'(row_mem[col]);
      sample_r     <= signed'(in_tdata);
      cell_r       <= (row != '0) && (col != '0);
      cell_row_r   <= row - 8'd1;
      cell_col_r   <= 8'(col_m1);
      step_r       <= bgu_pkg::clamp_step(step_cfg);
    end
    if (state_r == F_READ) begin
      ul_r  <= above_r;
      ll_r  <= sample_r;
      c00_r <= ul_r;
    end
  end

  assign e00 = bgu_pkg::ACC_W'(ul_r);
  assign e10 = bgu_pkg::ACC_W'(ll_r);
  assign e01 = bgu_pkg::ACC_W'(above_r);
  assign e11 = bgu_pkg::ACC_W'(sample_r);
  assign nx  = e10 - e00;
  assign ny  = e01 - e00;
  assign ne  = e11 - e10 - e01 + e00;

  assign step7 = bgu_pkg::DEN_W'(step_r);
  assign den   = step7 * step7;
  assign step6 = bgu_pkg::REM_W'(step_r);

  assign div_start = (state_r == F_READ) && cell_r;

  bgu_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (nx),
    .d     (step7),
    .busy  (busy_x),
    .q     (qx),
    .r     (rx)
  );

  bgu_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (ny),
    .d     (step7),
    .busy  (busy_y),
    .q     (qy),
    .r     (ry)
  );

  bgu_div u_div_e (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (ne),
    .d     (den),
    .busy  (busy_e),
    .q     (qe),
    .r     (re)
  );

  assign job_valid = (state_r == F_PUSH);

  always_comb begin
    job.c00  = bgu_pkg::ACC_W'(c00_r);
    job.qx   = qx;
    job.qy   = qy;
    job.qe   = qe;
    job.rx   = rx * step6;
    job.ry   = ry * step6;
    job.re   = re;
    job.den  = den;
    job.step = step_r;
    job.row  = cell_row_r;
    job.col  = cell_col_r;
  end

endmodule

@@ rtl/bgu_fifo.sv @@
// Two-entry queue of cell jobs between the front end and the point generator.
module bgu_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  bgu_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output bgu_pkg::job_t rd_data
);

  bgu_pkg::job_t slot_r [2];
  logic          wptr_r, rptr_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = slot_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wr_data;
    end
  end

endmodule

@@ rtl/bgu_back.sv @@
// Back end: walks the fine points of one cell with running quotient and remainder.
module bgu_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  bgu_pkg::job_t                job,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bgu_pkg::OUT_W-1:0]    out_tdata,
  output logic                         out_tlast
);

  bgu_pkg::job_t  job_r;
  bgu_pkg::qr_t   pt_r, base_r, del_r;
  bgu_pkg::qr_t   pt_step, base_step, del_step;
  bgu_pkg::qr_t   xinc, einc, start_pt, start_del;
  logic           active_r;
  logic [2:0]     iew_r, jew_r;
  logic [2:0]     last_idx;
  logic           last_col, last_pt, emit, load;
  logic           out_valid_r;
  logic           out_last_r;
  logic [bgu_pkg::OUT_W-1:0] out_data_r;

  assign last_idx = 3'(job_r.step - bgu_pkg::STEP_W'(1));
  assign last_col = (jew_r == last_idx);
  assign last_pt  = last_col && (iew_r == last_idx);
  assign emit     = active_r && (!out_valid_r || out_tready);
  assign load     = job_valid && (!active_r || (emit && last_pt));
  assign job_ready = load;

  assign xinc      = '{q: job_r.qx, r: job_r.rx};
  assign einc      = '{q: job_r.qe, r: job_r.re};
  assign start_pt  = '{q: job.c00, r: '0};
  assign start_del = '{q: job.qy, r: job.ry};

  assign pt_step   = bgu_pkg::qr_add(pt_r, del_r, job_r.den);
  assign base_step = bgu_pkg::qr_add(base_r, xinc, job_r.den);
  assign del_step  = bgu_pkg::qr_add(del_r, einc, job_r.den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (load) begin
      active_r <= 1'b1;
    end else if (emit && last_pt) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r  <= job;
      iew_r  <= '0;
      jew_r  <= '0;
      pt_r   <= start_pt;
      base_r <= start_pt;
      del_r  <= start_del;
    end else if (emit) begin
      if (last_col) begin
        iew_r  <= iew_r + 3'd1;
        jew_r  <= '0;
        base_r <= base_step;
        pt_r   <= base_step;
        del_r  <= del_step;
      end else begin
        jew_r <= jew_r + 3'd1;
        pt_r  <= pt_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {2'b00, jew_r, iew_r, job_r.col, job_r.row,
                     pt_r.q[bgu_pkg::SAMPLE_W-1:0]};
      out_last_r <= last_pt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/bilinear_grid_upsampler.sv @@
// Top level of the bilinear grid upsampler: configuration registers and block wiring.
//
// Coarse samples enter on the in_ stream in raster order, one Q16.16 value per
// beat; in_tuser marks the first sample of a new grid. Each sample past the
// first row and column closes a cell, and the out_ stream then carries all
// step*step fine points of that cell in raster order, out_tlast on the last.
// The cfg_ channel writes step (index 0) and coarse_cols (index 1); cfg_ready
// is always high. The user must make writes only while the block is idle;
// the block itself does not enforce this. A sample that closes no cell
// passes through the line-buffer read before the next sample is taken. A
// cell-closing sample holds the front end through the line-buffer read, a
// divider pass for the cell's increments and the hand-off to the job queue,
// which waits while the queue is full. The point generator then delivers one
// point per cycle when the receiver keeps up.
// Reset clears the counters, the job queue and the output stage, and sets
// step to 2 and coarse_cols to 256; the line buffer needs no clearing.
// When out_tready is low the output beat holds, the two-entry job queue
// fills, and then in_tready drops until the back end drains.
module bilinear_grid_upsampler #(
  parameter int MAX_COARSE_COLS = bgu_pkg::COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [31:0] coarse_sample
  input  logic                          in_tuser,   // [0] frame_start
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [31:0] fine_value, [39:32] cell_row, [47:40] cell_col,
  // [50:48] row_offset, [53:51] col_offset, [55:54] zero
  output logic [55:0]                   out_tdata,
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [0:0]                    cfg_index,
  input  logic [8:0]                    cfg_data
);

  logic [bgu_pkg::STEP_W-1:0] step_r;
  logic [bgu_pkg::COLS_W-1:0] cols_r;
  logic                       cfg_we;
  bgu_pkg::job_t              fe_job, be_job;
  logic                       fe_valid, fe_ready;
  logic                       be_valid, be_ready;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= bgu_pkg::STEP_W'(2);
      cols_r <= bgu_pkg::COLS_W'(256);
    end else if (cfg_we) begin
      case (bgu_pkg::cfg_idx_t'(cfg_index))
        bgu_pkg::CFG_STEP: step_r <= cfg_data[bgu_pkg::STEP_W-1:0];
        bgu_pkg::CFG_COLS: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bgu_front #(
    .MAX_COARSE_COLS (MAX_COARSE_COLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .step_cfg  (step_r),
    .cols_cfg  (cols_r),
    .job_valid (fe_valid),
    .job_ready (fe_ready),
    .job       (fe_job)
  );

  bgu_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_data  (fe_job),
    .rd_valid (be_valid),
    .rd_ready (be_ready),
    .rd_data  (be_job)
  );

  bgu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (be_valid),
    .job_ready  (be_ready),
    .job        (be_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
